// ===== design/fap_pkg.sv =====
// ---------------------------------------------------------------------------
// fap_pkg - shared types and constants for the FASTA 2-bit packer
// Transaction payload structs, character codes and the base-code function.
// ---------------------------------------------------------------------------
package fap_pkg;

    // Word geometry
    localparam int WORD_W             = 32;
    localparam int CODE_W             = 2;
    localparam int BASES_PER_WORD_DEF = 16;
    localparam int COUNT_OUT_W        = 5;

    // Characters of interest
    localparam logic [7:0] CHR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHR_HEADER  = 8'h3E;  // '>'
    localparam logic [7:0] CHR_COMMENT = 8'h3B;  // ';'
    localparam logic [7:0] CHR_FASTQ   = 8'h40;  // '@'

    // Base codes
    localparam logic [CODE_W-1:0] CODE_A = 2'd0;
    localparam logic [CODE_W-1:0] CODE_C = 2'd1;
    localparam logic [CODE_W-1:0] CODE_G = 2'd2;
    localparam logic [CODE_W-1:0] CODE_T = 2'd3;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0]      packed_word;
        logic [COUNT_OUT_W-1:0] bases_used;
        logic                   last_word;
    } t_out_item;

    typedef struct packed {
        logic              is_base;
        logic [CODE_W-1:0] code;
    } t_base;

    // Decode a text byte into a base code, either case
    function automatic t_base base_code(input logic [7:0] b);
        t_base res;
        res.is_base = 1'b1;
        res.code    = CODE_A;
        case (b)
            8'h41, 8'h61: res.code = CODE_A;
            8'h43, 8'h63: res.code = CODE_C;
            8'h47, 8'h67: res.code = CODE_G;
            8'h54, 8'h74: res.code = CODE_T;
            default:      res.is_base = 1'b0;
        endcase
        return res;
    endfunction

endpackage

// ===== design/fasta_to_2bit_packer_core.sv =====
// ---------------------------------------------------------------------------
// fasta_to_2bit_packer_core - FASTA text to 2-bit packed DNA words
// Skips header and comment lines, codes A/C/G/T and packs them first base
// lowest into 32-bit words; flushes a zero-filled last word at end of input.
// A word is valid in the out register the cycle after its last byte enters.
// Throughput: one byte per cycle unless the output word waits; the output
// register takes a new word in the same cycle the old one goes downstream.
// Reset: synchronous, active low; clears line state, open word and out valid.
// ---------------------------------------------------------------------------
module fasta_to_2bit_packer_core #(
    parameter int BASES_PER_WORD = fap_pkg::BASES_PER_WORD_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  fap_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output fap_pkg::t_out_item o_out_data
);
    import fap_pkg::*;

    localparam int CNT_W  = $clog2(BASES_PER_WORD + 1);
    localparam int LANE_N = (BASES_PER_WORD < WORD_W / CODE_W) ?
                            BASES_PER_WORD : WORD_W / CODE_W;

    // Line and word state
    logic              r_at_line_start, n_at_line_start;
    logic              r_in_header,     n_in_header;
    logic [WORD_W-1:0] r_acc,           n_acc;
    logic [CNT_W-1:0]  r_pending,       n_pending;

    // Output register
    logic              r_out_valid, n_out_valid;
    t_out_item         r_out,       n_out;

    logic              take;
    logic              is_nl;
    logic              hdr_line;
    t_base             dec;
    logic              kept;
    logic [CNT_W-1:0]  cnt_inc;
    logic [CNT_W-1:0]  count;
    logic              full;
    logic              emit;
    logic [WORD_W-1:0] acc_upd;

    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign take        = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Classify the byte against line state
    always_comb begin
        is_nl    = (i_in_data.text_byte == CHR_NEWLINE);
        hdr_line = !is_nl && (r_in_header || (r_at_line_start &&
                   (i_in_data.text_byte == CHR_HEADER ||
                    i_in_data.text_byte == CHR_COMMENT ||
                    i_in_data.text_byte == CHR_FASTQ)));
        dec      = base_code(i_in_data.text_byte);
        kept     = !is_nl && !hdr_line && dec.is_base;
        cnt_inc  = r_pending + CNT_W'(1);
        count    = kept ? cnt_inc : r_pending;
        full     = kept && (32'(cnt_inc) == BASES_PER_WORD);
        emit     = full || i_in_data.end_of_input;
    end

    // Write the new code into its lane of the open word
    always_comb begin
        acc_upd = r_acc;
        for (int i = 0; i < LANE_N; i++) begin
            if (kept && (32'(r_pending) == i)) begin
                acc_upd[i*CODE_W +: CODE_W] = dec.code;
            end
        end
    end

    // Next state for line tracking, word and output register
    always_comb begin
        n_at_line_start = r_at_line_start;
        n_in_header     = r_in_header;
        n_acc           = r_acc;
        n_pending       = r_pending;
        n_out_valid     = r_out_valid && !i_out_ready;
        n_out           = r_out;
        if (take) begin
            n_at_line_start = is_nl;
            n_in_header     = hdr_line;
            n_acc           = acc_upd;
            n_pending       = count;
            if (emit) begin
                n_out_valid          = 1'b1;
                n_out.packed_word    = acc_upd;
                n_out.bases_used     = COUNT_OUT_W'(32'(count));
                n_out.last_word      = i_in_data.end_of_input;
                n_acc                = '0;
                n_pending            = '0;
                if (i_in_data.end_of_input) begin
                    n_at_line_start = 1'b1;
                    n_in_header     = 1'b0;
                end
            end
        end
    end

    // Hold control state under reset; payload needs none
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_at_line_start <= 1'b1;
            r_in_header     <= 1'b0;
            r_acc           <= '0;
            r_pending       <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_at_line_start <= n_at_line_start;
            r_in_header     <= n_in_header;
            r_acc           <= n_acc;
            r_pending       <= n_pending;
            r_out_valid     <= n_out_valid;
        end
        r_out <= n_out;
    end

    // The open word never holds a full complement of bases
    a_pending_below_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_pending) < BASES_PER_WORD)
        else $error("open word count reached word size");

    // A word that is not the last one is always full
    a_mid_word_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.last_word) |->
        (r_out.bases_used == COUNT_OUT_W'(BASES_PER_WORD)))
        else $error("partial word emitted before end of input");

    // End of input flushes the last word and returns line and word state to reset
    a_end_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && i_in_data.end_of_input) |=>
        (r_pending == '0 && r_acc == '0 && r_at_line_start && !r_in_header &&
         r_out_valid && r_out.last_word))
        else $error("end of input did not flush and reset");

endmodule
